FILE: src/nfpa_pkg.sv
// Package for the next-fit page allocator.
// Holds the controller state type, command codes and status codes.
// No dependencies.
package nfpa_pkg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_GRANT,
        ST_FREE_RD,
        ST_FREE_CLR,
        ST_RESP
    } state_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        STAT_DONE     = 2'd0,
        STAT_REFUSED  = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } status_t;

endpackage

FILE: src/nfpa_if.sv
// Valid/ready channels of the next-fit page allocator.
// Request channel carries command, size and address; response carries the result.
// Depends on nothing.
interface nfpa_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] size_bytes;
    logic [31:0] address;

    modport source (output valid, command, size_bytes, address, input ready);
    modport sink   (input valid, command, size_bytes, address, output ready);
endinterface

interface nfpa_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] block_address;
    logic [1:0]  status;

    modport source (output valid, block_address, status, input ready);
    modport sink   (input valid, block_address, status, output ready);
endinterface

FILE: src/nfpa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Used for the page bitmap and the run-length table. No dependencies.
module nfpa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/next_fit_page_allocator_unit.sv
// Next-fit page allocator. After reset a clearing pass wipes both tables; no request
// is taken during it. An allocate in bump mode goes straight to marking its pages; in
// next-fit mode the bitmap memory is scanned one page per cycle, and each granted page
// is then marked busy in the bitmap. A free clears the bitmap bits of its run. Zero or
// oversize allocates and misaligned or out-of-heap frees go straight to the response; a
// free of a page that starts no block is answered after its run-length lookup. One
// request is in work at a time; a finished response is held in an output register while
// the next request is taken.
module next_fit_page_allocator_unit #(
    parameter int NUM_PAGES = 1024,
    parameter int PAGE_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    nfpa_req_if.sink    req,
    nfpa_rsp_if.source  rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(NUM_PAGES + 1);
    localparam int AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam logic [CW-1:0] NP = CW'(NUM_PAGES);
    localparam logic [31:0] PMASK = (32'd1 << PAGE_BITS) - 32'd1;

    nfpa_pkg::state_t state_reg, state_next;

    logic [19:0]   base_reg;
    logic          fit_mode_reg, fit_mode_next;
    logic [CW-1:0] next_page_reg, next_page_next;
    logic [CW-1:0] pages_reg, pages_next;
    logic [CW-1:0] old_reg, old_next;
    logic [CW-1:0] bound_reg, bound_next;
    logic [CW-1:0] scan_p_reg, scan_p_next;
    logic          chk_valid_reg, chk_valid_next;
    logic [CW-1:0] chk_p_reg, chk_p_next;
    logic [CW-1:0] count_reg, count_next;
    logic          wrap_reg, wrap_next;
    logic [CW-1:0] start_reg, start_next;
    logic [CW-1:0] wp_reg, wp_next;
    logic [CW-1:0] end_reg, end_next;
    logic [CW-1:0] clr_reg, clr_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic [31:0]   res_addr_reg, res_addr_next;
    logic          out_valid_reg, out_valid_next;
    logic [1:0]    out_status_reg, out_status_next;
    logic [31:0]   out_addr_reg, out_addr_next;

    // Memory ports
    logic          bm_we, bm_wdata, bm_rdata;
    logic [AW-1:0] bm_waddr, bm_raddr;
    logic          rl_we;
    logic [AW-1:0] rl_waddr, rl_raddr;
    logic [CW-1:0] rl_wdata, rl_rdata;

    nfpa_ram #(.WIDTH(1), .DEPTH(NUM_PAGES)) u_busy_ram (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    nfpa_ram #(.WIDTH(CW), .DEPTH(NUM_PAGES)) u_len_ram (
        .clk   (clk),
        .we    (rl_we),
        .waddr (rl_waddr),
        .wdata (rl_wdata),
        .raddr (rl_raddr),
        .rdata (rl_rdata)
    );

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {12'd0, base_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= 20'd0;
        end
        else if (psel && penable && pwrite && (paddr[2] == 1'b0))
        begin
            base_reg <= pwdata[19:0];
        end
    end

    // Request decode
    logic          accept;
    logic [32:0]   sum33, pages33;
    logic          alloc_bad, bump_fit;
    logic [CW-1:0] req_pages;
    logic [31:0]   base_addr, off, fpage32;
    logic          free_bad;
    logic [CW-1:0] free_page;

    assign accept    = req.valid && req.ready;
    assign sum33     = {1'b0, req.size_bytes} + {1'b0, PMASK};
    assign pages33   = sum33 >> PAGE_BITS;
    assign alloc_bad = (pages33 == 33'd0) || (pages33 > 33'(NUM_PAGES));
    assign req_pages = pages33[CW-1:0];
    assign bump_fit  = req_pages <= (NP - next_page_reg);
    assign base_addr = {12'd0, base_reg} << PAGE_BITS;
    assign off       = req.address - base_addr;
    assign fpage32   = off >> PAGE_BITS;
    assign free_bad  = ((off & PMASK) != 32'd0) || (fpage32 >= 32'(NUM_PAGES));
    assign free_page = fpage32[CW-1:0];

    // Scan status
    logic          hit, scan_more, scan_end;
    logic [CW-1:0] count_inc, wp_inc;
    logic [CW:0]   free_sum;
    logic [CW-1:0] free_end;
    logic [31:0]   start_addr;

    assign count_inc  = count_reg + CW'(1);
    assign wp_inc     = wp_reg + CW'(1);
    assign hit        = chk_valid_reg && !bm_rdata && (count_inc == pages_reg);
    assign scan_more  = scan_p_reg < bound_reg;
    assign scan_end   = !chk_valid_reg && !scan_more;
    assign free_sum   = {1'b0, start_reg} + {1'b0, rl_rdata};
    assign free_end   = (free_sum > {1'b0, NP}) ? NP : free_sum[CW-1:0];
    assign start_addr = ({12'd0, base_reg} + 32'(start_reg)) << PAGE_BITS;

    assign req.ready = (state_reg == nfpa_pkg::ST_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.block_address = out_addr_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nfpa_pkg::ST_CLEAR:
            begin
                if (clr_reg == NP - CW'(1))
                begin
                    state_next = nfpa_pkg::ST_IDLE;
                end
            end
            nfpa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.command == nfpa_pkg::CMD_ALLOC)
                    begin
                        if (alloc_bad)
                            state_next = nfpa_pkg::ST_RESP;
                        else if (!fit_mode_reg && bump_fit)
                            state_next = nfpa_pkg::ST_GRANT;
                        else
                            state_next = nfpa_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = free_bad ? nfpa_pkg::ST_RESP : nfpa_pkg::ST_FREE_RD;
                    end
                end
            end
            nfpa_pkg::ST_SCAN:
            begin
                if (hit)
                    state_next = nfpa_pkg::ST_GRANT;
                else if (scan_end && !wrap_reg)
                    state_next = nfpa_pkg::ST_RESP;
            end
            nfpa_pkg::ST_GRANT:
            begin
                if (wp_inc == end_reg)
                    state_next = nfpa_pkg::ST_RESP;
            end
            nfpa_pkg::ST_FREE_RD:
            begin
                state_next = (rl_rdata == '0) ? nfpa_pkg::ST_RESP : nfpa_pkg::ST_FREE_CLR;
            end
            nfpa_pkg::ST_FREE_CLR:
            begin
                if (wp_inc == end_reg)
                    state_next = nfpa_pkg::ST_RESP;
            end
            nfpa_pkg::ST_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                    state_next = nfpa_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = nfpa_pkg::ST_IDLE;
            end
        endcase
    end

    // Memory access and datapath updates
    always_comb
    begin
        fit_mode_next   = fit_mode_reg;
        next_page_next  = next_page_reg;
        pages_next      = pages_reg;
        old_next        = old_reg;
        bound_next      = bound_reg;
        scan_p_next     = scan_p_reg;
        chk_valid_next  = 1'b0;
        chk_p_next      = chk_p_reg;
        count_next      = count_reg;
        wrap_next       = wrap_reg;
        start_next      = start_reg;
        wp_next         = wp_reg;
        end_next        = end_reg;
        clr_next        = clr_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        bm_we    = 1'b0;
        bm_waddr = wp_reg[AW-1:0];
        bm_wdata = 1'b0;
        bm_raddr = scan_p_reg[AW-1:0];
        rl_we    = 1'b0;
        rl_waddr = start_reg[AW-1:0];
        rl_wdata = '0;
        rl_raddr = free_page[AW-1:0];
        case (state_reg)
            nfpa_pkg::ST_CLEAR:
            begin
                // Wipe one entry of each table per cycle
                bm_we    = 1'b1;
                bm_waddr = clr_reg[AW-1:0];
                rl_we    = 1'b1;
                rl_waddr = clr_reg[AW-1:0];
                clr_next = clr_reg + CW'(1);
            end
            nfpa_pkg::ST_IDLE:
            begin
                res_addr_next = 32'd0;
                if (accept && req.command == nfpa_pkg::CMD_ALLOC)
                begin
                    pages_next      = req_pages;
                    res_status_next = nfpa_pkg::STAT_REFUSED;
                    count_next      = '0;
                    if (!alloc_bad)
                    begin
                        if (!fit_mode_reg && bump_fit)
                        begin
                            start_next = next_page_reg;
                            wp_next    = next_page_reg;
                            end_next   = next_page_reg + req_pages;
                        end
                        else if (!fit_mode_reg)
                        begin
                            // Switch to next-fit: one pass over the whole heap
                            fit_mode_next  = 1'b1;
                            next_page_next = '0;
                            scan_p_next    = '0;
                            bound_next     = NP;
                            wrap_next      = 1'b0;
                        end
                        else
                        begin
                            old_next    = next_page_reg;
                            scan_p_next = next_page_reg;
                            bound_next  = NP;
                            wrap_next   = 1'b1;
                        end
                    end
                end
                else if (accept)
                begin
                    res_status_next = free_bad ? nfpa_pkg::STAT_NOT_FOUND
                                               : nfpa_pkg::STAT_DONE;
                    start_next      = free_page;
                    wp_next         = free_page;
                end
            end
            nfpa_pkg::ST_SCAN:
            begin
                if (chk_valid_reg)
                begin
                    if (bm_rdata)
                    begin
                        count_next     = '0;
                        next_page_next = chk_p_reg + CW'(1);
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                if (hit)
                begin
                    start_next = next_page_reg;
                    wp_next    = next_page_reg;
                    end_next   = next_page_reg + pages_reg;
                end
                else if (scan_more)
                begin
                    // Issue the next bitmap read
                    chk_valid_next = 1'b1;
                    chk_p_next     = scan_p_reg;
                    scan_p_next    = scan_p_reg + CW'(1);
                end
                else if (scan_end && wrap_reg)
                begin
                    // Wrap to page 0 and search up to the old pointer
                    next_page_next = '0;
                    scan_p_next    = '0;
                    bound_next     = old_reg;
                    count_next     = '0;
                    wrap_next      = 1'b0;
                end
            end
            nfpa_pkg::ST_GRANT:
            begin
                bm_we    = 1'b1;
                bm_wdata = 1'b1;
                wp_next  = wp_inc;
                if (wp_reg == start_reg)
                begin
                    rl_we    = 1'b1;
                    rl_wdata = pages_reg;
                end
                if (wp_inc == end_reg)
                begin
                    next_page_next  = end_reg;
                    res_status_next = nfpa_pkg::STAT_DONE;
                    res_addr_next   = start_addr;
                end
            end
            nfpa_pkg::ST_FREE_RD:
            begin
                end_next = free_end;
                if (rl_rdata == '0)
                begin
                    res_status_next = nfpa_pkg::STAT_NOT_FOUND;
                end
                else
                begin
                    rl_we = 1'b1;
                end
            end
            nfpa_pkg::ST_FREE_CLR:
            begin
                bm_we   = 1'b1;
                wp_next = wp_inc;
            end
            nfpa_pkg::ST_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_addr_next   = res_addr_reg;
                end
            end
            default:
            begin
                chk_valid_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nfpa_pkg::ST_CLEAR;
            fit_mode_reg  <= 1'b0;
            next_page_reg <= '0;
            chk_valid_reg <= 1'b0;
            wrap_reg      <= 1'b0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fit_mode_reg  <= fit_mode_next;
            next_page_reg <= next_page_next;
            chk_valid_reg <= chk_valid_next;
            wrap_reg      <= wrap_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pages_reg      <= pages_next;
        old_reg        <= old_next;
        bound_reg      <= bound_next;
        scan_p_reg     <= scan_p_next;
        chk_p_reg      <= chk_p_next;
        count_reg      <= count_next;
        start_reg      <= start_next;
        wp_reg         <= wp_next;
        end_reg        <= end_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
    end

    // Checks
    a_next_page_range: assert property (@(posedge clk) disable iff (!rst_n)
        next_page_reg <= NP)
        else $error("roving pointer beyond heap");

    a_fit_mode_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        fit_mode_reg |=> fit_mode_reg)
        else $error("fit mode dropped back to bump mode");

    a_mark_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nfpa_pkg::ST_GRANT || state_reg == nfpa_pkg::ST_FREE_CLR)
        |-> (wp_reg < end_reg && end_reg <= NP))
        else $error("bitmap write outside run");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_status_reg == nfpa_pkg::STAT_DONE
                           || out_status_reg == nfpa_pkg::STAT_REFUSED
                           || out_status_reg == nfpa_pkg::STAT_NOT_FOUND))
        else $error("invalid status code");

endmodule

FILE: verif/next_fit_page_allocator_unit_test.sv
// Self-checking test of the next-fit page allocator unit.
// Depends on nfpa_pkg, nfpa_if.sv and next_fit_page_allocator_unit.sv.
module next_fit_page_allocator_unit_test;

    localparam int NUM_PAGES = 1024;
    localparam int PAGE_BITS = 12;
    localparam longint CYCLE_LIMIT = 12000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    nfpa_req_if req ();
    nfpa_rsp_if rsp ();

    next_fit_page_allocator_unit #(.NUM_PAGES(NUM_PAGES), .PAGE_BITS(PAGE_BITS)) dut (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    typedef struct packed {
        logic [31:0]       block_address;
        nfpa_pkg::status_t status;
    } alloc_result_t;

    // Predictor state
    logic [19:0] base_page;
    bit          busy_map [NUM_PAGES];
    int unsigned run_len [NUM_PAGES];
    int unsigned rover;
    bit          next_fit;

    alloc_result_t expected_results [$];
    int unsigned live_blocks [$];
    int          error_count = 0;
    longint      cycle_count = 0;
    int          hold_off_cycles = 0;
    bit          hold_off_req = 1'b0;
    bit          hold_off_ack = 1'b0;
    bit          stall_random = 1'b1;

    always #1 clk = ~clk;

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    function automatic logic [31:0] page_address(input int unsigned page);
        logic [31:0] sum;
        sum = 32'(base_page) + 32'(page);
        return sum << PAGE_BITS;
    endfunction

    function automatic void mark_run(input int unsigned start, input int unsigned pages);
        for (int unsigned i = 0; i < pages && start + i < NUM_PAGES; i++)
            busy_map[start + i] = 1'b1;
        run_len[start] = pages;
        rover = start + pages;
        live_blocks.push_back(start);
    endfunction

    function automatic bit find_free_run(input int unsigned from, input int unsigned bound,
                                         input int unsigned pages);
        int unsigned cnt;
        cnt = 0;
        if (bound > NUM_PAGES)
            bound = NUM_PAGES;
        for (int unsigned p = from; p < bound; p++)
        begin
            if (busy_map[p])
            begin
                cnt = 0;
                rover = p + 1;
            end
            else
            begin
                cnt++;
                if (cnt == pages)
                    return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Work out the response of one request and update the predictor
    function automatic alloc_result_t predict_request(input nfpa_pkg::command_t cmd,
                                                      input logic [31:0] size,
                                                      input logic [31:0] addr);
        alloc_result_t r;
        longint unsigned pages64;
        int unsigned pages, old, page;
        logic [31:0] off;
        bit hit;
        r.block_address = '0;
        r.status = nfpa_pkg::STAT_DONE;
        if (cmd == nfpa_pkg::CMD_ALLOC)
        begin
            pages64 = (longint'(size) + (1 << PAGE_BITS) - 1) >> PAGE_BITS;
            if (pages64 == 0 || pages64 > NUM_PAGES)
            begin
                r.status = nfpa_pkg::STAT_REFUSED;
                return r;
            end
            pages = int'(pages64);
            if (!next_fit)
            begin
                if (rover <= NUM_PAGES && pages <= NUM_PAGES - rover)
                begin
                    old = rover;
                    mark_run(old, pages);
                    r.block_address = page_address(old);
                    return r;
                end
                next_fit = 1'b1;
                rover = 0;
                hit = find_free_run(0, NUM_PAGES, pages);
            end
            else
            begin
                old = rover;
                hit = find_free_run(old, NUM_PAGES, pages);
                if (!hit)
                begin
                    rover = 0;
                    hit = find_free_run(0, old, pages);
                end
            end
            if (hit)
            begin
                old = rover;
                mark_run(old, pages);
                r.block_address = page_address(old);
            end
            else
                r.status = nfpa_pkg::STAT_REFUSED;
            return r;
        end
        off = addr - page_address(0);
        page = off >> PAGE_BITS;
        if (off[PAGE_BITS-1:0] != 0 || page >= NUM_PAGES || run_len[page] == 0)
        begin
            r.status = nfpa_pkg::STAT_NOT_FOUND;
            return r;
        end
        for (int unsigned i = 0; i < run_len[page] && page + i < NUM_PAGES; i++)
            busy_map[page + i] = 1'b0;
        run_len[page] = 0;
        foreach (live_blocks[i])
            if (live_blocks[i] == page)
            begin
                live_blocks.delete(i);
                break;
            end
        return r;
    endfunction

    // Send one request, predicting its response on acceptance
    task automatic send_request(input nfpa_pkg::command_t cmd, input logic [31:0] size,
                                input logic [31:0] addr);
        req.valid <= 1'b1;
        req.command <= cmd;
        req.size_bytes <= size;
        req.address <= addr;
        do
            @(posedge clk);
        while (!req.ready);
        expected_results.push_back(predict_request(cmd, size, addr));
    endtask

    task automatic idle_request();
        req.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (2200) @(posedge clk);
    endtask

    task automatic write_base(input logic [19:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'd0;
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        base_page = value;
    endtask

    // Receiver stall pattern and long hold-off
    always @(posedge clk)
    begin
        if (hold_off_req != hold_off_ack)
        begin
            hold_off_ack <= hold_off_req;
            hold_off_cycles <= 3000;
            rsp.ready <= 1'b0;
        end
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp.ready <= 1'b0;
        end
        else if (stall_random)
            rsp.ready <= ($urandom_range(0, 3) != 0);
        else
            rsp.ready <= 1'b1;
    end

    // Compare each accepted response with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            alloc_result_t want;
            if (expected_results.size() == 0)
            begin
                $display("MISMATCH unexpected response at cycle %0d", cycle_count);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (rsp.block_address !== want.block_address)
                    report_mismatch("block_address", rsp.block_address, want.block_address);
                if (rsp.status !== want.status)
                    report_mismatch("status", 32'(rsp.status), 32'(want.status));
            end
        end
    end

    function automatic logic [31:0] random_size();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return $urandom_range(0, 3);
            2: return $urandom_range(1, 64) << PAGE_BITS;
            default: return $urandom_range(1, 16 << PAGE_BITS);
        endcase
    endfunction

    function automatic logic [31:0] free_target();
        int unsigned k;
        if (live_blocks.size() != 0 && $urandom_range(0, 5) != 0)
        begin
            k = $urandom_range(0, live_blocks.size() - 1);
            return page_address(live_blocks[k]);
        end
        case ($urandom_range(0, 2))
            0: return $urandom();
            1: return page_address($urandom_range(0, NUM_PAGES - 1));
            default: return page_address($urandom_range(0, NUM_PAGES - 1)) + 32'd4;
        endcase
    endfunction

    task automatic random_traffic(input int count);
        int left;
        left = count;
        while (left > 0)
        begin
            // Burst, then a random gap
            for (int b = $urandom_range(1, 12); b > 0 && left > 0; b--, left--)
            begin
                if ($urandom_range(0, 1) == 0)
                    send_request(nfpa_pkg::CMD_ALLOC, random_size(), $urandom());
                else
                    send_request(nfpa_pkg::CMD_FREE, $urandom(), free_target());
            end
            repeat ($urandom_range(0, 4)) idle_request();
        end
    endtask

    task automatic test_directed_edges();
        send_request(nfpa_pkg::CMD_ALLOC, 32'd0, 32'hFFFF_FFFF);
        send_request(nfpa_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 32'd0);
        send_request(nfpa_pkg::CMD_ALLOC, (NUM_PAGES << PAGE_BITS) + 1, 32'd0);
        send_request(nfpa_pkg::CMD_ALLOC, 32'd1, 32'd0);
        send_request(nfpa_pkg::CMD_ALLOC, 32'd4096, 32'd0);
        send_request(nfpa_pkg::CMD_ALLOC, 32'd4097, 32'd0);
        send_request(nfpa_pkg::CMD_FREE, 32'hFFFF_FFFF, page_address(1));
        send_request(nfpa_pkg::CMD_FREE, 32'd0, page_address(1));
        send_request(nfpa_pkg::CMD_FREE, 32'd0, page_address(0) + 1);
        send_request(nfpa_pkg::CMD_FREE, 32'd0, page_address(NUM_PAGES));
        send_request(nfpa_pkg::CMD_FREE, 32'd0, page_address(500));
        // Fill to the end exactly, then force the switch to next-fit
        send_request(nfpa_pkg::CMD_ALLOC, (NUM_PAGES - 4) << PAGE_BITS, 32'd0);
        send_request(nfpa_pkg::CMD_FREE, 32'd0, page_address(0));
        send_request(nfpa_pkg::CMD_ALLOC, 32'd4096, 32'd0);
        send_request(nfpa_pkg::CMD_ALLOC, 32'd4096, 32'd0);
        send_request(nfpa_pkg::CMD_FREE, 32'd0, page_address(4));
        send_request(nfpa_pkg::CMD_ALLOC, (NUM_PAGES - 4) << PAGE_BITS, 32'd0);
        send_request(nfpa_pkg::CMD_ALLOC, NUM_PAGES << PAGE_BITS, 32'd0);
        drain();
    endtask

    task automatic test_full_heap_and_base(input logic [19:0] value);
        write_base(value);
        send_request(nfpa_pkg::CMD_FREE, 32'd0, free_target());
        while (live_blocks.size() != 0)
            send_request(nfpa_pkg::CMD_FREE, 32'd0, page_address(live_blocks[0]));
        send_request(nfpa_pkg::CMD_ALLOC, NUM_PAGES << PAGE_BITS, 32'd0);
        send_request(nfpa_pkg::CMD_FREE, 32'd0, page_address(0));
        drain();
    endtask

    task automatic test_backpressure();
        hold_off_req = ~hold_off_req;
        random_traffic(20);
        drain();
    endtask

    initial
    begin
        base_page = '0;
        rover = 0;
        next_fit = 1'b0;
        for (int i = 0; i < NUM_PAGES; i++)
        begin
            busy_map[i] = 1'b0;
            run_len[i] = 0;
        end
        req.valid = 1'b0;
        req.command = nfpa_pkg::CMD_ALLOC;
        req.size_bytes = '0;
        req.address = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (NUM_PAGES + 10) @(posedge clk);

        test_directed_edges();
        test_full_heap_and_base(20'hFFFFF);
        random_traffic(600);
        drain();
        test_backpressure();
        test_full_heap_and_base(20'h12345);
        stall_random = 1'b0;
        random_traffic(500);
        drain();
        stall_random = 1'b1;
        test_full_heap_and_base(20'h00000);
        random_traffic(600);
        drain();

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

FILE: files.f
src/nfpa_pkg.sv
src/nfpa_if.sv
src/nfpa_ram.sv
src/next_fit_page_allocator_unit.sv
verif/next_fit_page_allocator_unit_test.sv
